// ----- design/tof_pkg.sv -----
package tof_pkg;

  localparam int MAX_ROW_PIXELS   = 512;
  localparam int MAX_FRAME_PIXELS = 131072;

  localparam int ROW_AW = $clog2(MAX_ROW_PIXELS);
  localparam int PIX_AW = $clog2(MAX_FRAME_PIXELS);
  localparam int TOT_W  = PIX_AW + 1;

  localparam int DIM_W    = 10;
  localparam int CFG_W    = 10;
  localparam int CFG_AW   = 2;
  localparam int VAL_W    = 12;
  localparam int AMB_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int PEND_W   = 24;
  localparam int PREV_W   = 29;
  localparam int AMP_LSB  = 12;
  localparam int AMB_LSB  = 24;
  localparam int FLAG_BIT = 28;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_PACKED_MODE  = 2'd2,
    CFG_HDR_ENABLE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             packed_mode;
    logic             hdr_enable;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0]  phase;
    logic [VAL_W-1:0]  amplitude;
    logic [AMB_W-1:0]  ambient;
    logic              overexposed;
    logic              last_pixel;
    logic              row_amp;
    logic [PIX_AW-1:0] addr;
  } pix_t;

  typedef struct packed {
    logic busy;
    logic hold;
  } merge_stat_t;

endpackage

// ----- design/tof_raw_frame_unpack_hdr_merge.sv -----
// Raw time-of-flight frame unpacker with optional HDR merge. One raw byte is
// taken per clock while in_stall_o is low; each byte that completes a pixel
// passes that pixel through the s1_q register onto the output register. The
// sustained rate is one byte per cycle while unstalled, limited by the byte-wide
// input, with one read and one write port on each pixel store. After reset the
// previous-frame store (131072 entries) is swept to zero, one entry per cycle,
// holding in_stall_o high meanwhile; configuration writes are taken during
// that sweep. Change the configuration only when no transfer is in flight.
module tof_raw_frame_unpack_hdr_merge
  import tof_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] raw_byte_i,
  input  logic              frame_start_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [VAL_W-1:0]  phase_o,
  output logic [VAL_W-1:0]  amplitude_o,
  output logic [AMB_W-1:0]  ambient_o,
  output logic              overexposed_o,
  output logic              last_pixel_o
);

  cfg_t              cfg_q;
  merge_stat_t       stat;
  pix_t              pix;
  logic              emit, accept;
  logic [BYTE_W-1:0] row_amp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= DIM_W'(320);
      cfg_q.frame_height <= DIM_W'(240);
      cfg_q.packed_mode  <= 1'b0;
      cfg_q.hdr_enable   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_wdata_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_wdata_i[DIM_W-1:0];
        CFG_PACKED_MODE:  cfg_q.packed_mode  <= cfg_wdata_i[0];
        CFG_HDR_ENABLE:   cfg_q.hdr_enable   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = stat.busy || stat.hold;
  assign accept     = in_valid_i && !in_stall_o;

  tof_unpack u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .raw_byte_i   (raw_byte_i),
    .frame_start_i(frame_start_i),
    .emit_o       (emit),
    .pix_o        (pix),
    .row_amp_o    (row_amp)
  );

  tof_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hdr_enable_i (cfg_q.hdr_enable),
    .accept_i     (accept),
    .emit_i       (emit),
    .pix_i        (pix),
    .row_amp_i    (row_amp),
    .out_stall_i  (out_stall_i),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .phase_o      (phase_o),
    .amplitude_o  (amplitude_o),
    .ambient_o    (ambient_o),
    .overexposed_o(overexposed_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

// ----- design/tof_ram.sv -----
module tof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tof_unpack.sv -----
module tof_unpack
  import tof_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] raw_byte_i,
  input  logic              frame_start_i,
  output logic              emit_o,
  output pix_t              pix_o,
  output logic [BYTE_W-1:0] row_amp_o
);

  logic [PEND_W-1:0] pend_q, pend_d, pend;
  logic [1:0]        bpos_q, bpos_d, bpos;
  logic [ROW_AW-1:0] col_q, col_d, col;
  logic [PIX_AW-1:0] pix_q, pix_d, pix;
  logic              ph_q, ph_d, ph;

  logic [DIM_W-1:0]   eff_w, eff_h, col_inc;
  logic [2*DIM_W-1:0] prod;
  logic [TOT_W-1:0]   total, pix_next;
  logic               col_wrap, last, emit;
  logic               row_we, row_re;
  logic [15:0]        word;

  always_comb begin
    eff_w = cfg_i.frame_width;
    if (eff_w == '0) begin
      eff_w = DIM_W'(1);
    end else if (eff_w > DIM_W'(MAX_ROW_PIXELS)) begin
      eff_w = DIM_W'(MAX_ROW_PIXELS);
    end
    eff_h = (cfg_i.frame_height == '0) ? DIM_W'(1) : cfg_i.frame_height;
    prod  = eff_w * eff_h;
    total = (prod > (2*DIM_W)'(MAX_FRAME_PIXELS)) ? TOT_W'(MAX_FRAME_PIXELS)
                                                   : prod[TOT_W-1:0];
  end

  assign pend = frame_start_i ? '0 : pend_q;
  assign bpos = frame_start_i ? '0 : bpos_q;
  assign col  = frame_start_i ? '0 : col_q;
  assign pix  = frame_start_i ? '0 : pix_q;
  assign ph   = frame_start_i ? 1'b0 : ph_q;

  assign col_inc  = {{(DIM_W-ROW_AW){1'b0}}, col} + DIM_W'(1);
  assign col_wrap = col_inc >= eff_w;
  assign pix_next = {1'b0, pix} + TOT_W'(1);
  assign last     = pix_next >= total;
  assign word     = {raw_byte_i, pend[7:0]};

  always_comb begin
    pend_d = pend;
    bpos_d = bpos;
    col_d  = col;
    pix_d  = pix;
    ph_d   = ph;
    emit   = 1'b0;
    row_we = 1'b0;
    row_re = 1'b0;
    pix_o  = '0;
    pix_o.addr       = pix;
    pix_o.last_pixel = last;
    if (cfg_i.packed_mode) begin
      if (!ph) begin
        row_we = 1'b1;
        bpos_d = '0;
        col_d  = col_wrap ? '0 : col_inc[ROW_AW-1:0];
        ph_d   = col_wrap;
      end else if (bpos == '0) begin
        pend_d = {{(PEND_W-BYTE_W){1'b0}}, raw_byte_i};
        bpos_d = 2'd1;
      end else begin
        emit   = 1'b1;
        row_re = 1'b1;
        bpos_d = '0;
        col_d  = col_wrap ? '0 : col_inc[ROW_AW-1:0];
        ph_d   = !col_wrap;
        pix_o.phase       = word[11:0];
        pix_o.ambient     = {word[14:12], 1'b0};
        pix_o.overexposed = word[15];
        pix_o.row_amp     = 1'b1;
      end
    end else begin
      case (bpos)
        2'd0: begin
          pend_d = {{(PEND_W-BYTE_W){1'b0}}, raw_byte_i};
          bpos_d = 2'd1;
        end
        2'd1: begin
          pend_d = {pend[23:16], raw_byte_i, pend[7:0]};
          bpos_d = 2'd2;
        end
        2'd2: begin
          pend_d = {raw_byte_i, pend[15:0]};
          bpos_d = 2'd3;
        end
        default: begin
          emit   = 1'b1;
          bpos_d = '0;
          pix_o.phase       = {raw_byte_i[3:0], pend[23:16]};
          pix_o.amplitude   = pend[11:0];
          pix_o.ambient     = pend[15:12];
          pix_o.overexposed = raw_byte_i[7];
        end
      endcase
    end
    if (emit) begin
      if (last) begin
        pend_d = '0;
        bpos_d = '0;
        col_d  = '0;
        pix_d  = '0;
        ph_d   = 1'b0;
      end else begin
        pix_d = pix_next[PIX_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      bpos_q <= '0;
      col_q  <= '0;
      pix_q  <= '0;
      ph_q   <= 1'b0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      bpos_q <= bpos_d;
      col_q  <= col_d;
      pix_q  <= pix_d;
      ph_q   <= ph_d;
    end
  end

  tof_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_ROW_PIXELS)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (accept_i && row_we),
    .waddr_i(col),
    .wdata_i(raw_byte_i),
    .re_i   (accept_i && row_re),
    .raddr_i(col),
    .rdata_o(row_amp_o)
  );

  assign emit_o = emit;

`ifndef SYNTH
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && emit && last |=> pix_q == '0 && col_q == '0 && !ph_q && bpos_q == '0)
    else $error("counters not cleared after last pixel");

  a_pix_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !frame_start_i && emit && !last |=> pix_q == $past(pix_q) + PIX_AW'(1))
    else $error("pixel index did not advance by one");
`endif

endmodule

// ----- design/tof_merge.sv -----
module tof_merge
  import tof_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hdr_enable_i,
  input  logic              accept_i,
  input  logic              emit_i,
  input  pix_t              pix_i,
  input  logic [BYTE_W-1:0] row_amp_i,
  input  logic              out_stall_i,
  output merge_stat_t       stat_o,
  output logic              out_valid_o,
  output logic [VAL_W-1:0]  phase_o,
  output logic [VAL_W-1:0]  amplitude_o,
  output logic [AMB_W-1:0]  ambient_o,
  output logic              overexposed_o,
  output logic              last_pixel_o
);

  pix_t              s1_q;
  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [PREV_W-1:0] out_q, out_d;
  logic              out_last_q;
  logic              busy_q;
  logic [PIX_AW-1:0] clr_cnt_q;

  logic              s1_go, hold, take_prev;
  logic [VAL_W-1:0]  cur_amp;
  logic [PREV_W-1:0] cur, prev;
  logic              prev_we;
  logic [PIX_AW-1:0] prev_waddr;
  logic [PREV_W-1:0] prev_wdata;

  assign hold  = s1_valid_q && out_valid_q && out_stall_i;
  assign s1_go = s1_valid_q && !(out_valid_q && out_stall_i);

  assign cur_amp = s1_q.row_amp ? {row_amp_i, 4'b0000} : s1_q.amplitude;
  assign cur     = {s1_q.overexposed, s1_q.ambient, cur_amp, s1_q.phase};

  assign take_prev = hdr_enable_i && !prev[FLAG_BIT] &&
                     (s1_q.overexposed || prev[AMP_LSB +: VAL_W] >= cur_amp);
  assign out_d     = take_prev ? prev : cur;

  assign s1_valid_d  = (accept_i && emit_i) || (s1_valid_q && !s1_go);
  assign out_valid_d = s1_go || (out_valid_q && out_stall_i);

  assign prev_we    = busy_q || (s1_go && hdr_enable_i);
  assign prev_waddr = busy_q ? clr_cnt_q : s1_q.addr;
  assign prev_wdata = busy_q ? '0 : cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      busy_q      <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (busy_q) begin
        clr_cnt_q <= clr_cnt_q + PIX_AW'(1);
        if (clr_cnt_q == PIX_AW'(MAX_FRAME_PIXELS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && emit_i) begin
      s1_q <= pix_i;
    end
    if (s1_go) begin
      out_q      <= out_d;
      out_last_q <= s1_q.last_pixel;
    end
  end

  tof_ram #(
    .WIDTH(PREV_W),
    .DEPTH(MAX_FRAME_PIXELS)
  ) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (prev_we),
    .waddr_i(prev_waddr),
    .wdata_i(prev_wdata),
    .re_i   (accept_i && emit_i && hdr_enable_i),
    .raddr_i(pix_i.addr),
    .rdata_o(prev)
  );

  assign stat_o.busy   = busy_q;
  assign stat_o.hold   = hold;
  assign out_valid_o   = out_valid_q;
  assign phase_o       = out_q[VAL_W-1:0];
  assign amplitude_o   = out_q[AMP_LSB +: VAL_W];
  assign ambient_o     = out_q[AMB_LSB +: AMB_W];
  assign overexposed_o = out_q[FLAG_BIT];
  assign last_pixel_o  = out_last_q;

`ifndef SYNTH
  a_no_pixel_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s1_valid_q)
    else $error("pixel in flight during store clear");

  a_hold_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |=> s1_valid_q && $stable(s1_q.addr))
    else $error("held pixel lost");

  a_go_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> out_valid_q)
    else $error("advanced pixel missing at output");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import tof_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
  } raw_xfer_t;

  typedef struct packed {
    logic [VAL_W-1:0] phase;
    logic [VAL_W-1:0] amplitude;
    logic [AMB_W-1:0] ambient;
    logic             overexposed;
    logic             last_pixel;
  } depth_pix_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]  cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] raw_byte_i    = '0;
  logic              frame_start_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [VAL_W-1:0]  phase_o;
  logic [VAL_W-1:0]  amplitude_o;
  logic [AMB_W-1:0]  ambient_o;
  logic              overexposed_o;
  logic              last_pixel_o;

  tof_raw_frame_unpack_hdr_merge u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .raw_byte_i   (raw_byte_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .phase_o      (phase_o),
    .amplitude_o  (amplitude_o),
    .ambient_o    (ambient_o),
    .overexposed_o(overexposed_o),
    .last_pixel_o (last_pixel_o)
  );

  always #10 clk_i = ~clk_i;

  raw_xfer_t  byte_q[$];
  depth_pix_t pix_q[$];
  raw_xfer_t  next_xfer;
  depth_pix_t got_pix;
  depth_pix_t want_pix;

  int errors        = 0;
  int send_pct      = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;
  int stuck_cycles  = 0;
  int items_pushed  = 0;
  bit pending_start = 1'b0;

  // Shadow of the block: configuration, counters and stores.
  logic [DIM_W-1:0]  cfg_width  = 10'd320;
  logic [DIM_W-1:0]  cfg_height = 10'd240;
  logic              cfg_packed = 1'b0;
  logic              cfg_hdr    = 1'b0;
  bit [BYTE_W-1:0]   row_amp_mem [MAX_ROW_PIXELS];
  bit [PREV_W-1:0]   prev_mem    [MAX_FRAME_PIXELS];
  logic [PEND_W-1:0] pend_bytes = '0;
  int                byte_pos   = 0;
  int                col_idx    = 0;
  int                pix_idx    = 0;
  bit                phase_half = 1'b0;

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
    return int'(cfg_width);
  endfunction

  function automatic int frame_total();
    int h;
    int t;
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    t = eff_width() * h;
    return (t > MAX_FRAME_PIXELS) ? MAX_FRAME_PIXELS : t;
  endfunction

  function automatic int frame_bytes();
    if (cfg_packed) return (frame_total() / eff_width()) * 3 * eff_width();
    return 4 * frame_total();
  endfunction

  task automatic clear_counters();
    pend_bytes = '0;
    byte_pos   = 0;
    col_idx    = 0;
    pix_idx    = 0;
    phase_half = 1'b0;
  endtask

  task automatic merge_pixel(logic [VAL_W-1:0] ph, logic [VAL_W-1:0] amp,
                             logic [AMB_W-1:0] amb, logic flag);
    logic [PREV_W-1:0] cur;
    logic [PREV_W-1:0] sel;
    logic [PREV_W-1:0] prev;
    depth_pix_t        pix;
    cur = {flag, amb, amp, ph};
    sel = cur;
    if (cfg_hdr) begin
      prev = prev_mem[pix_idx];
      if (prev[FLAG_BIT]) begin
        sel = cur;
      end else if (flag) begin
        sel = prev;
      end else begin
        sel = (amp > prev[AMP_LSB +: VAL_W]) ? cur : prev;
      end
      prev_mem[pix_idx] = cur;
    end
    pix.phase       = sel[VAL_W-1:0];
    pix.amplitude   = sel[AMP_LSB +: VAL_W];
    pix.ambient     = sel[AMB_LSB +: AMB_W];
    pix.overexposed = sel[FLAG_BIT];
    pix.last_pixel  = (pix_idx + 1 >= frame_total());
    if (pix.last_pixel) begin
      clear_counters();
    end else begin
      pix_idx++;
    end
    pix_q.push_back(pix);
  endtask

  task automatic take_byte(logic [BYTE_W-1:0] b, logic start);
    logic [15:0]      word;
    logic [VAL_W-1:0] amp;
    if (start) clear_counters();
    if (cfg_packed) begin
      if (!phase_half) begin
        if (col_idx < MAX_ROW_PIXELS) row_amp_mem[col_idx] = b;
        byte_pos = 0;
        col_idx++;
        if (col_idx >= eff_width()) begin
          col_idx    = 0;
          phase_half = 1'b1;
        end
      end else if (byte_pos == 0) begin
        pend_bytes = {16'h0000, b};
        byte_pos   = 1;
      end else begin
        word = {b, pend_bytes[7:0]};
        amp  = (col_idx < MAX_ROW_PIXELS) ? {row_amp_mem[col_idx], 4'h0} : '0;
        byte_pos = 0;
        col_idx++;
        if (col_idx >= eff_width()) begin
          col_idx    = 0;
          phase_half = 1'b0;
        end
        merge_pixel(word[11:0], amp, {word[14:12], 1'b0}, word[15]);
      end
    end else if (byte_pos < 3) begin
      if (byte_pos == 0) begin
        pend_bytes = {16'h0000, b};
      end else begin
        pend_bytes = pend_bytes | (PEND_W'(b) << (8 * byte_pos));
      end
      byte_pos++;
    end else begin
      word     = {b, pend_bytes[23:16]};
      byte_pos = 0;
      merge_pixel(word[11:0], pend_bytes[11:0], pend_bytes[15:12], word[15]);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) take_byte(raw_byte_i, frame_start_i);
      if (!in_valid_i || !in_stall_o) begin
        if (byte_q.size() != 0 && !chance(send_pct)) begin
          next_xfer = byte_q.pop_front();
          in_valid_i    <= 1'b1;
          raw_byte_i    <= next_xfer.data;
          frame_start_i <= next_xfer.start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= chance(stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_pix = {phase_o, amplitude_o, ambient_o, overexposed_o, last_pixel_o};
      if (pix_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel %p", got_pix);
      end else begin
        want_pix = pix_q.pop_front();
        if (got_pix.phase !== want_pix.phase || got_pix.amplitude !== want_pix.amplitude ||
            got_pix.ambient !== want_pix.ambient ||
            got_pix.overexposed !== want_pix.overexposed ||
            got_pix.last_pixel !== want_pix.last_pixel) begin
          errors++;
          if (errors <= 10) $display("pixel mismatch: expected %p, got %p", want_pix, got_pix);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  cfg_width  = val[DIM_W-1:0];
      CFG_FRAME_HEIGHT: cfg_height = val[DIM_W-1:0];
      CFG_PACKED_MODE:  cfg_packed = val[0];
      CFG_HDR_ENABLE:   cfg_hdr    = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int w, int h, int pk, int hdr);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_PACKED_MODE, pk);
    write_reg(CFG_HDR_ENABLE, hdr);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_valid_i || pix_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic push_byte(logic [BYTE_W-1:0] b, logic start);
    raw_xfer_t x;
    x.data  = b;
    x.start = start | pending_start;
    pending_start = 1'b0;
    byte_q.push_back(x);
    items_pushed++;
  endtask

  task automatic push_word(logic [15:0] w);
    push_byte(w[7:0], 1'b0);
    push_byte(w[15:8], 1'b0);
  endtask

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(7, 0))
      0: return 8'h00;
      1: return 8'hFF;
      default: return BYTE_W'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(7, 0))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535, 0));
    endcase
  endfunction

  // Push one frame under the shadow configuration, keeping its first keep bytes.
  task automatic push_frame(int keep);
    int base;
    int w;
    base = items_pushed;
    w    = eff_width();
    pending_start = 1'b1;
    if (cfg_packed) begin
      for (int r = 0; r < frame_total() / w; r++) begin
        for (int c = 0; c < w; c++) push_byte(rand_byte(), 1'b0);
        for (int c = 0; c < w; c++) push_word(rand_word());
      end
    end else begin
      for (int p = 0; p < frame_total(); p++) begin
        push_word(rand_word());
        push_word(rand_word());
      end
    end
    while (items_pushed > base + keep) begin
      void'(byte_q.pop_back());
      items_pushed--;
    end
  endtask

  initial begin
    int base;
    int sel;
    int w;
    int h;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(700, 1, 1, 0);
    pending_start = 1'b1;
    for (int c = 0; c < MAX_ROW_PIXELS; c++) begin
      push_byte((c == 0) ? 8'h00 : (c == 1) ? 8'hFF : rand_byte(), 1'b0);
    end
    push_word(16'h0000);
    push_word(16'hFFFF);
    drain();

    set_config(2, 2, 0, 1);
    pending_start = 1'b1;
    push_word(16'h0000); push_word(16'h0000);
    push_word(16'hFFFF); push_word(16'hFFFF);
    push_word(16'h0800); push_word(16'h7FFF);
    push_word(16'hF123); push_word(16'h8ABC);
    push_word(16'h0001); push_word(16'h1234);
    push_word(16'h0FFF); push_word(16'h0000);
    push_word(16'h07FF); push_word(16'h0555);
    push_word(16'h0FFF); push_word(16'h8000);
    push_word(16'h5A5A);
    push_byte(8'hC3, 1'b1);
    push_byte(8'h3C, 1'b0);
    push_word(16'hA5A5);
    drain();

    set_config(0, 0, 1, 1);
    push_byte(8'hFF, 1'b1);
    push_word(16'hFFFF);
    push_byte(8'h00, 1'b0);
    push_word(16'h0000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      sel = $urandom_range(9, 0);
      if (ph == 0) sel = 3;
      w = (sel == 0) ? 0 : (sel == 1) ? 1 :
          (sel == 2) ? $urandom_range(1023, 512) : $urandom_range(8, 2);
      h = (sel == 2) ? $urandom_range(1, 0) : $urandom_range(4, 0);
      set_config(w, h, $urandom_range(1, 0), $urandom_range(1, 0));
      case (ph % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 75; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 75; end
        default: begin send_pct = 24; stall_pct = 24; end
      endcase
      if (ph == 0) begin
        hold_cycles = 1500;
        push_frame(frame_bytes());
      end
      base = items_pushed;
      while (items_pushed - base < 24) begin
        sel = $urandom_range(9, 0);
        if (sel < 7 && eff_width() <= 8) begin
          push_frame(frame_bytes());
        end else if (sel < 8) begin
          push_frame($urandom_range(23, 1));
        end else begin
          repeat ($urandom_range(8, 1)) push_byte(rand_byte(), $urandom_range(3, 0) == 0);
        end
      end
      drain();
    end

    send_pct  = 0;
    stall_pct = 0;
    drain();
    errors += pix_q.size();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
